FILE: hw/rtl/sphc_pkg.sv
// Shared types, codes and helpers of the sphere pair collision time block.
`timescale 1ns / 1ps

package sphc_pkg;

  typedef enum logic [1:0] {
    ReqLoad     = 2'd0,
    ReqParticle = 2'd1,
    ReqObstacle = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CfgContactPart = 2'd0,
    CfgContactObst = 2'd1,
    CfgTimeStep    = 2'd2
  } cfg_idx_e;

  localparam int unsigned QueueDepth = 4;
  localparam logic [30:0] CfgReset   = 31'd65536;

  typedef struct packed {
    logic [30:0] contact_part;
    logic [30:0] contact_obst;
    logic [30:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic [15:0] tag;
    logic        obstacle;
    logic        loaded;
    logic [30:0] ref_stamp;
    logic [30:0] stamp;
  } cand_t;

  function automatic logic [31:0] sat32(input logic signed [49:0] x);
    logic [31:0] r;
    if (!x[49] && (|x[48:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (x[49] && !(&x[48:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/sphc_queue.sv
// Small first-in first-out queue between the front and the back.
`timescale 1ns / 1ps

module sphc_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          push_ok, pop_ok;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_d = (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/sphc_front.sv
// Front: holds the reference particle and forms offset and relative velocity.
`timescale 1ns / 1ps

module sphc_front #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [1:0]                   req_type_i,
  input  logic [DIMENSIONS-1:0][31:0]  pos_i,
  input  logic [DIMENSIONS-1:0][31:0]  vel_i,
  input  logic [30:0]                  stamp_i,
  input  logic [15:0]                  tag_i,
  output logic                         q_push_o,
  output sphc_pkg::cand_t              q_cand_o,
  output logic [DIMENSIONS-1:0][31:0]  q_d_o,
  output logic [DIMENSIONS-1:0][31:0]  q_vd_o,
  input  logic                         q_full_i
);
  import sphc_pkg::*;

  logic [DIMENSIONS-1:0][31:0] rpos_q, rvel_q;
  logic [30:0]                 rstamp_q;
  logic                        loaded_q;

  logic                        a_valid_q, a_valid_d;
  cand_t                       a_cand_q;
  logic [DIMENSIONS-1:0][32:0] a_base_q, a_base_d, a_vd_q, a_vd_d;
  logic [DIMENSIONS-1:0][46:0] a_m1_q, a_m1_d, a_m2_q, a_m2_d;
  logic [DIMENSIONS-1:0]       a_m1n_q, a_m1n_d, a_m2n_q, a_m2n_d;

  logic accept, is_load, is_cand, advance;
  logic [31:0] absr, absv;
  logic [62:0] p1, p2;
  logic signed [49:0] sum, sm1, sm2, vdx;

  assign full_o   = a_valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign is_load  = (req_type_i == ReqLoad);
  assign is_cand  = (req_type_i == ReqParticle) || (req_type_i == ReqObstacle);
  assign advance  = !a_valid_q || !q_full_i;
  assign q_push_o = a_valid_q;
  assign q_cand_o = a_cand_q;

  always_comb begin
    a_base_d = a_base_q;
    a_vd_d   = a_vd_q;
    a_m1_d   = a_m1_q;
    a_m2_d   = a_m2_q;
    a_m1n_d  = a_m1n_q;
    a_m2n_d  = a_m2n_q;
    absr     = '0;
    absv     = '0;
    p1       = '0;
    p2       = '0;
    for (int i = 0; i < DIMENSIONS; i++) begin
      absr = rvel_q[i][31] ? 32'(0 - rvel_q[i]) : rvel_q[i];
      absv = vel_i[i][31] ? 32'(0 - vel_i[i]) : vel_i[i];
      p1   = 63'(absr) * 63'(rstamp_q);
      p2   = 63'(absv) * 63'(stamp_i);
      a_m1_d[i]   = p1[62:16];
      a_m2_d[i]   = p2[62:16];
      a_m1n_d[i]  = rvel_q[i][31];
      a_m2n_d[i]  = vel_i[i][31];
      a_base_d[i] = {rpos_q[i][31], rpos_q[i]} - {pos_i[i][31], pos_i[i]};
      a_vd_d[i]   = {rvel_q[i][31], rvel_q[i]} - {vel_i[i][31], vel_i[i]};
    end
  end

  always_comb begin
    q_d_o  = '0;
    q_vd_o = '0;
    sum    = '0;
    sm1    = '0;
    sm2    = '0;
    vdx    = '0;
    for (int i = 0; i < DIMENSIONS; i++) begin
      sm1 = a_m1n_q[i] ? 50'(0 - {3'b0, a_m1_q[i]}) : {3'b0, a_m1_q[i]};
      sm2 = a_m2n_q[i] ? 50'(0 - {3'b0, a_m2_q[i]}) : {3'b0, a_m2_q[i]};
      sum = {{17{a_base_q[i][32]}}, a_base_q[i]} - sm1 + sm2;
      vdx = {{17{a_vd_q[i][32]}}, a_vd_q[i]};
      q_d_o[i]  = sat32(sum);
      q_vd_o[i] = sat32(vdx);
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (advance) begin
      a_valid_d = accept && is_cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpos_q    <= '0;
      rvel_q    <= '0;
      rstamp_q  <= '0;
      loaded_q  <= 1'b0;
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      if (accept && is_load) begin
        rpos_q   <= pos_i;
        rvel_q   <= vel_i;
        rstamp_q <= stamp_i;
        loaded_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_cand) begin
      a_cand_q.tag       <= tag_i;
      a_cand_q.obstacle  <= (req_type_i == ReqObstacle);
      a_cand_q.loaded    <= loaded_q;
      a_cand_q.ref_stamp <= rstamp_q;
      a_cand_q.stamp     <= stamp_i;
      a_base_q           <= a_base_d;
      a_vd_q             <= a_vd_d;
      a_m1_q             <= a_m1_d;
      a_m2_q             <= a_m2_d;
      a_m1n_q            <= a_m1n_d;
      a_m2n_q            <= a_m2n_d;
    end
  end

endmodule

FILE: hw/rtl/sphc_back.sv
// Back: sequencer with shared multiplier, divider and square root per candidate.
`timescale 1ns / 1ps

module sphc_back #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sphc_pkg::cfg_t              cfg_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  sphc_pkg::cand_t             q_cand_i,
  input  logic [DIMENSIONS-1:0][31:0] q_d_i,
  input  logic [DIMENSIONS-1:0][31:0] q_vd_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [15:0]                 echo_tag_o,
  output logic                        collides_o,
  output logic [31:0]                 collision_time_o
);
  import sphc_pkg::*;

  localparam int unsigned DimW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam logic [DimW-1:0] LastDim = DimW'(DIMENSIONS - 1);
  localparam logic [1:0] SubDd = 2'd0;
  localparam logic [1:0] SubVv = 2'd1;
  localparam logic [1:0] SubDv = 2'd2;

  typedef enum logic [8:0] {
    SIdle    = 9'b000000001,
    SMul     = 9'b000000010,
    SChk     = 9'b000000100,
    SDivInit = 9'b000001000,
    SDiv     = 9'b000010000,
    SPhSq    = 9'b000100000,
    SSqrt    = 9'b001000000,
    SFin     = 9'b010000000,
    SDone    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  cand_t ent_q, ent_d;
  logic [DIMENSIONS-1:0][31:0] d_q, d_d, vd_q, vd_d;
  logic [DimW-1:0] idx_q, idx_d;
  logic [1:0] sub_q, sub_d;
  logic [63:0] dd_q, dd_d, vv_q, vv_d, pos_q, pos_d, neg_q, neg_d;
  logic [4:0] cnt_q, cnt_d;
  logic [63:0] div_r_q, div_r_d;
  logic [30:0] quo_q, quo_d;
  logic div_second_q, div_second_d;
  logic [31:0] ph_q, ph_d, qv_q, qv_d;
  logic [63:0] x_q, x_d, res_q, res_d, bit_q, bit_d;
  logic col_q, col_d;
  logic [31:0] time_q, time_d;
  logic out_valid_q, out_valid_d;
  logic [15:0] out_tag_q, out_tag_d;
  logic out_col_q, out_col_d;
  logic [31:0] out_time_q, out_time_d;

  logic [31:0] md, mv, ph_mag, mul_a, mul_b, div_val, t32;
  logic [63:0] prod, dvd, qnum, contact, div_num, trial;
  logic dvd_neg, q_neg, div_neg, cap, ge, sq_ge, t_ok;
  logic [64:0] r2, r2_sub;
  logic [30:0] quo_next;
  logic signed [48:0] det;
  logic signed [49:0] t_wide;

  function automatic logic [31:0] sdiv(input logic neg, input logic [31:0] r);
    logic [31:0] v;
    if (neg) begin
      v = 32'(0 - r);
    end else begin
      v = r[31] ? 32'h7FFF_FFFF : r;
    end
    return v;
  endfunction

  assign md = d_q[idx_q][31] ? 32'(0 - d_q[idx_q]) : d_q[idx_q];
  assign mv = vd_q[idx_q][31] ? 32'(0 - vd_q[idx_q]) : vd_q[idx_q];
  assign ph_mag = ph_q[31] ? 32'(0 - ph_q) : ph_q;

  always_comb begin
    if (state_q == SPhSq) begin
      mul_a = ph_mag;
      mul_b = ph_mag;
    end else begin
      case (sub_q)
        SubDd:   begin mul_a = md; mul_b = md; end
        SubVv:   begin mul_a = mv; mul_b = mv; end
        default: begin mul_a = md; mul_b = mv; end
      endcase
    end
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  assign dvd_neg = neg_q > pos_q;
  assign dvd     = dvd_neg ? neg_q - pos_q : pos_q - neg_q;
  assign contact = {17'b0, (ent_q.obstacle ? cfg_i.contact_obst : cfg_i.contact_part), 16'b0};
  assign q_neg   = dd_q < contact;
  assign qnum    = q_neg ? contact - dd_q : dd_q - contact;
  assign div_num = div_second_q ? qnum : dvd;
  assign div_neg = div_second_q ? q_neg : dvd_neg;
  assign cap     = {15'b0, div_num} >= {vv_q, 15'b0};

  assign r2       = {div_r_q, cnt_q[4] & div_num[cnt_q[3:0]]};
  assign ge       = r2 >= {1'b0, vv_q};
  assign r2_sub   = r2 - {1'b0, vv_q};
  assign quo_next = {quo_q[29:0], ge};
  assign div_val  = (state_q == SDivInit) ? sdiv(div_neg, 32'h8000_0000)
                                          : sdiv(div_neg, {1'b0, quo_next});

  assign det   = $signed({1'b0, prod[63:16]}) - $signed({{17{qv_q[31]}}, qv_q});
  assign trial = res_q + bit_q;
  assign sq_ge = x_q >= trial;

  assign t_wide = 50'(0 - $signed({{18{ph_q[31]}}, ph_q})) - $signed({18'b0, res_q[31:0]});
  assign t32    = sat32(t_wide);
  assign t_ok   = ($signed(t32) > $signed({1'b0, ent_q.ref_stamp}))
               && ($signed(t32) > $signed({1'b0, ent_q.stamp}))
               && ($signed(t32) <= $signed({1'b0, cfg_i.time_step}));

  assign q_pop_o = (state_q == SIdle) && !q_empty_i;

  always_comb begin
    state_d      = state_q;
    ent_d        = ent_q;
    d_d          = d_q;
    vd_d         = vd_q;
    idx_d        = idx_q;
    sub_d        = sub_q;
    dd_d         = dd_q;
    vv_d         = vv_q;
    pos_d        = pos_q;
    neg_d        = neg_q;
    cnt_d        = cnt_q;
    div_r_d      = div_r_q;
    quo_d        = quo_q;
    div_second_d = div_second_q;
    ph_d         = ph_q;
    qv_d         = qv_q;
    x_d          = x_q;
    res_d        = res_q;
    bit_d        = bit_q;
    col_d        = col_q;
    time_d       = time_q;
    out_valid_d  = out_valid_q && !pop_i;
    out_tag_d    = out_tag_q;
    out_col_d    = out_col_q;
    out_time_d   = out_time_q;

    unique case (state_q)
      SIdle: begin
        if (!q_empty_i) begin
          ent_d  = q_cand_i;
          d_d    = q_d_i;
          vd_d   = q_vd_i;
          idx_d  = '0;
          sub_d  = SubDd;
          dd_d   = '0;
          vv_d   = '0;
          pos_d  = '0;
          neg_d  = '0;
          col_d  = 1'b0;
          time_d = '0;
          state_d = q_cand_i.loaded ? SMul : SDone;
        end
      end
      SMul: begin
        case (sub_q)
          SubDd: dd_d = dd_q + prod;
          SubVv: vv_d = vv_q + prod;
          default: begin
            if (d_q[idx_q][31] != vd_q[idx_q][31]) begin
              neg_d = neg_q + prod;
            end else begin
              pos_d = pos_q + prod;
            end
          end
        endcase
        if (sub_q == SubDv) begin
          sub_d = SubDd;
          if (idx_q == LastDim) begin
            state_d = SChk;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          sub_d = sub_q + 1'b1;
        end
      end
      SChk: begin
        div_second_d = 1'b0;
        state_d = (vv_q == '0) ? SDone : SDivInit;
      end
      SDivInit: begin
        if (cap) begin
          if (!div_second_q) begin
            ph_d = div_val;
            div_second_d = 1'b1;
          end else begin
            qv_d = div_val;
            state_d = SPhSq;
          end
        end else begin
          div_r_d = {15'b0, div_num[63:15]};
          cnt_d   = 5'd30;
          quo_d   = '0;
          state_d = SDiv;
        end
      end
      SDiv: begin
        div_r_d = ge ? r2_sub[63:0] : r2[63:0];
        quo_d   = quo_next;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (!div_second_q) begin
            ph_d = div_val;
            div_second_d = 1'b1;
            state_d = SDivInit;
          end else begin
            qv_d = div_val;
            state_d = SPhSq;
          end
        end
      end
      SPhSq: begin
        x_d     = {1'b0, det[46:0], 16'b0};
        res_d   = '0;
        bit_d   = 64'h4000_0000_0000_0000;
        cnt_d   = 5'd31;
        state_d = det[48] ? SDone : SSqrt;
      end
      SSqrt: begin
        if (sq_ge) begin
          x_d   = x_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = SFin;
        end
      end
      SFin: begin
        col_d   = t_ok;
        time_d  = t_ok ? t32 : '0;
        state_d = SDone;
      end
      SDone: begin
        if (!out_valid_q || pop_i) begin
          out_valid_d = 1'b1;
          out_tag_d   = ent_q.tag;
          out_col_d   = col_q;
          out_time_d  = time_q;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q        <= ent_d;
    d_q          <= d_d;
    vd_q         <= vd_d;
    idx_q        <= idx_d;
    sub_q        <= sub_d;
    dd_q         <= dd_d;
    vv_q         <= vv_d;
    pos_q        <= pos_d;
    neg_q        <= neg_d;
    cnt_q        <= cnt_d;
    div_r_q      <= div_r_d;
    quo_q        <= quo_d;
    div_second_q <= div_second_d;
    ph_q         <= ph_d;
    qv_q         <= qv_d;
    x_q          <= x_d;
    res_q        <= res_d;
    bit_q        <= bit_d;
    col_q        <= col_d;
    time_q       <= time_d;
    out_tag_q    <= out_tag_d;
    out_col_q    <= out_col_d;
    out_time_q   <= out_time_d;
  end

  assign empty_o          = !out_valid_q;
  assign echo_tag_o       = out_tag_q;
  assign collides_o       = out_col_q;
  assign collision_time_o = out_time_q;

  a_no_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_col_q) |-> (out_time_q == '0))
    else $error("time nonzero without collision");

  a_col_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_col_q) |-> ($signed(out_time_q) > 0))
    else $error("collision time not positive");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDiv) |-> (div_r_q < vv_q))
    else $error("divider remainder out of range");

endmodule

FILE: hw/rtl/sphere_pair_collision_time.sv
// Top level of the sphere pair collision time block.
`timescale 1ns / 1ps

// Usage:
//   Input queue: drive req_type_i and the payload with push_i; a transaction
//   completes when push_i is high and full_o is low. A load (type 0) stores
//   the reference particle and gives no result; type 3 is dropped.
//   Candidates (types 1 and 2) give exactly one result each, in order.
//   Result queue: while empty_o is low the oldest result is on echo_tag_o,
//   collides_o and collision_time_o; pop_i takes it.
//   Configuration: write cfg_wdata_i into register cfg_idx_i with cfg_we_i,
//   only while no candidate is in flight.
//   A full solve runs two 31-step divisions and a 32-step square root on one
//   shared sequencer; a candidate with no reference or with equal velocities
//   skips them. The back works on one candidate at a time and takes the next
//   only when it is done with the last; the front takes one item per cycle
//   until its stage and the four-entry queue fill.
//   Reset clears the reference and sets every register to 1.0.
//   A stalled receiver holds the result; the back then stops, the queue
//   fills and full_o rises.
module sphere_pair_collision_time #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [30:0] stamp_i,
  input  logic [15:0] tag_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] echo_tag_o,
  output logic        collides_o,
  output logic [31:0] collision_time_o
);
  import sphc_pkg::*;

  localparam int unsigned EntW = $bits(cand_t) + 64 * DIMENSIONS;

  cfg_t cfg_q, cfg_d;
  logic [2:0][31:0] pos_all, vel_all;
  logic q_push, q_full, q_pop, q_empty;
  cand_t f_cand, b_cand;
  logic [DIMENSIONS-1:0][31:0] f_d, f_vd, b_d, b_vd;
  logic [EntW-1:0] q_wdata, q_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgContactPart: cfg_d.contact_part = cfg_wdata_i;
        CfgContactObst: cfg_d.contact_obst = cfg_wdata_i;
        CfgTimeStep:    cfg_d.time_step    = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{contact_part: CfgReset, contact_obst: CfgReset, time_step: CfgReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign pos_all = {pos_z_i, pos_y_i, pos_x_i};
  assign vel_all = {vel_z_i, vel_y_i, vel_x_i};

  sphc_front #(.DIMENSIONS(DIMENSIONS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .req_type_i (req_type_i),
    .pos_i      (pos_all[DIMENSIONS-1:0]),
    .vel_i      (vel_all[DIMENSIONS-1:0]),
    .stamp_i    (stamp_i),
    .tag_i      (tag_i),
    .q_push_o   (q_push),
    .q_cand_o   (f_cand),
    .q_d_o      (f_d),
    .q_vd_o     (f_vd),
    .q_full_i   (q_full)
  );

  assign q_wdata = {f_cand, f_d, f_vd};
  assign {b_cand, b_d, b_vd} = q_rdata;

  sphc_queue #(.W(EntW), .DEPTH(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  sphc_back #(.DIMENSIONS(DIMENSIONS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .q_cand_i         (b_cand),
    .q_d_i            (b_d),
    .q_vd_i           (b_vd),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .echo_tag_o       (echo_tag_o),
    .collides_o       (collides_o),
    .collision_time_o (collision_time_o)
  );

endmodule
